[rtl/core/gnpg_pkg.sv]
// Shared constants, types and gradient tables for the gradient noise pixel generator.
package gnpg_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int ANGLE_STEPS = 360;

	localparam int PIX_W   = 12;
	localparam int DIM_W   = 13;
	localparam int SCALE_W = 16;
	localparam int SEED_W  = 32;
	localparam int CFG_W   = 32;
	localparam int GREY_W  = 8;

	localparam int PROD_W = PIX_W + SCALE_W;
	localparam int NUM_W  = PROD_W + FRAC_BITS - 8;
	localparam int CELL_W = NUM_W - FRAC_BITS;
	localparam int SM_W   = FRAC_BITS + 1;
	localparam int Q_W    = 16;
	localparam int ANG_W  = $clog2(ANGLE_STEPS);
	localparam int HASH_W = 32;

	localparam int HASH_LAT  = 5;
	localparam int BLEND_LAT = 6;

	localparam logic [HASH_W-1:0] HASH_C1 = 32'd374761393;
	localparam logic [HASH_W-1:0] HASH_C2 = 32'd668265263;
	localparam logic [HASH_W-1:0] HASH_C3 = 32'd1274126177;
	localparam logic [63:0] MOD_RECIP = (64'd1 << 32) / 64'(ANGLE_STEPS);

	localparam logic [63:0] Q28_ONE    = 64'd268435456;
	localparam logic [63:0] TWO_PI_Q28 = 64'd1686629713;

	typedef enum logic [1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_SCALE  = 2'd2,
		REG_SEED   = 2'd3
	} cfg_idx_t;

	typedef logic signed [Q_W-1:0] q14_t;
	typedef logic [ANGLE_STEPS-1:0][Q_W-1:0] tab_t;

	// Q28 Taylor series, eleven terms, rounded to Q1.14 and limited to +-1.0
	function automatic tab_t gen_tab(input logic want_cos);
		tab_t t;
		logic [63:0] m, x, x2, term, mag, r;
		logic signed [63:0] sacc, cacc, v;
		logic neg;
		for (int k = 0; k < ANGLE_STEPS; k++) begin
			m = 64'(k);
			neg = 1'b0;
			if (2 * k > ANGLE_STEPS) begin
				m = 64'(ANGLE_STEPS - k);
				neg = 1'b1;
			end
			x = (m * TWO_PI_Q28 + 64'(ANGLE_STEPS / 2)) / 64'(ANGLE_STEPS);
			x2 = (x * x) >> 28;
			term = x;
			sacc = $signed(term);
			for (int i = 1; i <= 10; i++) begin
				term = ((term * x2) >> 28) / 64'((2 * i) * (2 * i + 1));
				if (i % 2 == 1) sacc = sacc - $signed(term);
				else sacc = sacc + $signed(term);
			end
			term = Q28_ONE;
			cacc = $signed(term);
			for (int i = 1; i <= 10; i++) begin
				term = ((term * x2) >> 28) / 64'((2 * i - 1) * (2 * i));
				if (i % 2 == 1) cacc = cacc - $signed(term);
				else cacc = cacc + $signed(term);
			end
			v = want_cos ? cacc : (neg ? -sacc : sacc);
			mag = (v < 0) ? 64'(-v) : 64'(v);
			r = (mag + 64'd8192) >> 14;
			if (r > 64'd16384) r = 64'd16384;
			t[k] = (v < 0) ? Q_W'(-$signed(r)) : Q_W'(r);
		end
		return t;
	endfunction

	localparam tab_t COS_TAB = gen_tab(1'b1);
	localparam tab_t SIN_TAB = gen_tab(1'b0);

endpackage

[rtl/core/gnpg_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
module gnpg_div (
	input  logic                          clk,
	input  logic                          adv,
	input  logic [gnpg_pkg::NUM_W-1:0]    num,
	input  logic [gnpg_pkg::DIM_W-1:0]    den,
	output logic [gnpg_pkg::NUM_W-1:0]    quo
);
	import gnpg_pkg::*;

	logic [NUM_W-1:0] n_s [NUM_W+1];
	logic [DIM_W-1:0] r_s [NUM_W+1];

	assign n_s[0] = num;
	assign r_s[0] = '0;

	for (genvar i = 0; i < NUM_W; i++) begin : g_stage
		logic [DIM_W:0] trial;
		logic [DIM_W:0] diff;
		logic           ge;
		always_comb begin
			trial = {r_s[i], n_s[i][NUM_W-1]};
			diff  = trial - {1'b0, den};
			ge    = (trial >= {1'b0, den});
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				r_s[i+1] <= ge ? diff[DIM_W-1:0] : trial[DIM_W-1:0];
				n_s[i+1] <= {n_s[i][NUM_W-2:0], ge};
			end
		end
	end

	assign quo = n_s[NUM_W];
endmodule

[rtl/core/gnpg_hash.sv]
// Corner hash, angle reduction and gradient table lookup for the four cell corners.
module gnpg_hash (
	input  logic                          clk,
	input  logic                          adv,
	input  logic [gnpg_pkg::CELL_W-1:0]   cell_x,
	input  logic [gnpg_pkg::CELL_W-1:0]   cell_y,
	input  logic [gnpg_pkg::SEED_W-1:0]   seed,
	output gnpg_pkg::q14_t                grad_cos [4],
	output gnpg_pkg::q14_t                grad_sin [4]
);
	import gnpg_pkg::*;

	for (genvar k = 0; k < 4; k++) begin : g_corner
		logic [HASH_W-1:0] cx, cy, hx, hy;
		logic [HASH_W-1:0] mix2, mix3;
		logic [63:0]       qp;
		logic [HASH_W-1:0] rem0, rem1, rem2;
		logic [HASH_W-1:0] h_s1, h_s2, h_s3, q_s3;
		logic [ANG_W-1:0]  ang_s4;
		q14_t              cos_s5, sin_s5;

		always_comb begin
			cx   = HASH_W'(cell_x) + HASH_W'(k % 2);
			cy   = HASH_W'(cell_y) + HASH_W'(k / 2);
			hx   = cx * HASH_C1;
			hy   = cy * HASH_C2;
			mix2 = h_s1 ^ (h_s1 >> 13);
			mix3 = h_s2 ^ (h_s2 >> 16);
			qp   = {32'b0, mix3} * MOD_RECIP;
			// reciprocal estimate is low by at most two
			rem0 = h_s3 - HASH_W'(q_s3 * HASH_W'(ANGLE_STEPS));
			rem1 = (rem0 >= HASH_W'(ANGLE_STEPS)) ? rem0 - HASH_W'(ANGLE_STEPS) : rem0;
			rem2 = (rem1 >= HASH_W'(ANGLE_STEPS)) ? rem1 - HASH_W'(ANGLE_STEPS) : rem1;
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				h_s1   <= hx + hy + seed;
				h_s2   <= mix2 * HASH_C3;
				h_s3   <= mix3;
				q_s3   <= qp[63:32];
				ang_s4 <= rem2[ANG_W-1:0];
				cos_s5 <= q14_t'(COS_TAB[ang_s4]);
				sin_s5 <= q14_t'(SIN_TAB[ang_s4]);
			end
		end

		assign grad_cos[k] = cos_s5;
		assign grad_sin[k] = sin_s5;
	end
endmodule

[rtl/core/gnpg_blend.sv]
// Corner dot products, smoothstep-weighted interpolation and grey mapping.
module gnpg_blend (
	input  logic                          clk,
	input  logic                          adv,
	input  logic [gnpg_pkg::FRAC_BITS-1:0] frac_x,
	input  logic [gnpg_pkg::FRAC_BITS-1:0] frac_y,
	input  logic [gnpg_pkg::SM_W-1:0]     smooth_x,
	input  logic [gnpg_pkg::SM_W-1:0]     smooth_y,
	input  gnpg_pkg::q14_t                grad_cos [4],
	input  gnpg_pkg::q14_t                grad_sin [4],
	output logic [gnpg_pkg::GREY_W-1:0]   grey
);
	import gnpg_pkg::*;

	localparam int DX_W  = FRAC_BITS + 2;
	localparam int DOT_W = Q_W + DX_W;
	localparam int W_W   = SM_W + 1;
	localparam int P1_W  = DOT_W + W_W;
	localparam int L_W   = P1_W - FRAC_BITS;
	localparam int P2_W  = L_W + W_W;
	localparam int N_W   = P2_W - FRAC_BITS;
	localparam int G_W   = N_W + 10;
	localparam logic signed [DX_W-1:0] ONE_DX = DX_W'(1) <<< FRAC_BITS;
	localparam logic signed [W_W-1:0]  ONE_W  = W_W'(1) <<< FRAC_BITS;
	localparam logic signed [N_W-1:0]  BIAS   = N_W'(1) <<< (14 + FRAC_BITS);

	logic signed [DX_W-1:0] dx0, dx1, dy0, dy1;
	logic signed [DOT_W-1:0] dot_s1 [4];
	logic [SM_W-1:0] sx_s1, sy_s1, sy_s2, sy_s3;
	logic signed [W_W-1:0] wx, wx_n, wy, wy_n;
	logic signed [P1_W-1:0] p_s2 [4];
	logic signed [P1_W-1:0] top_sum, bot_sum;
	logic signed [L_W-1:0] top_s3, bot_s3;
	logic signed [P2_W-1:0] pa_s4, pb_s4, n_sum;
	logic signed [N_W-1:0] n_s5, biased;
	logic [G_W-1:0] scaled;
	logic [GREY_W-1:0] grey_s6, grey_d;

	always_comb begin
		dx0  = $signed({2'b0, frac_x});
		dx1  = dx0 - ONE_DX;
		dy0  = $signed({2'b0, frac_y});
		dy1  = dy0 - ONE_DX;
		wx   = $signed({1'b0, sx_s1});
		wx_n = ONE_W - wx;
		wy   = $signed({1'b0, sy_s3});
		wy_n = ONE_W - wy;
		top_sum = p_s2[0] + p_s2[1];
		bot_sum = p_s2[2] + p_s2[3];
		n_sum   = pa_s4 + pb_s4;
		biased  = n_s5 + BIAS;
		scaled  = G_W'(biased) * G_W'(255);
		// negative blend saturates to black, large to white
		if (biased < 0) grey_d = '0;
		else if ((scaled >> (15 + FRAC_BITS)) > G_W'(255)) grey_d = '1;
		else grey_d = GREY_W'(scaled >> (15 + FRAC_BITS));
	end

	for (genvar k = 0; k < 4; k++) begin : g_dot
		logic signed [DX_W-1:0] dx, dy;
		assign dx = (k % 2 == 1) ? dx1 : dx0;
		assign dy = (k / 2 == 1) ? dy1 : dy0;
		always_ff @(posedge clk) begin
			if (adv) begin
				dot_s1[k] <= grad_cos[k] * dx + grad_sin[k] * dy;
				p_s2[k]   <= dot_s1[k] * ((k % 2 == 1) ? wx : wx_n);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sx_s1   <= smooth_x;
			sy_s1   <= smooth_y;
			sy_s2   <= sy_s1;
			top_s3  <= L_W'(top_sum >>> FRAC_BITS);
			bot_s3  <= L_W'(bot_sum >>> FRAC_BITS);
			sy_s3   <= sy_s2;
			pa_s4   <= top_s3 * wy_n;
			pb_s4   <= bot_s3 * wy;
			n_s5    <= N_W'(n_sum >>> FRAC_BITS);
			grey_s6 <= grey_d;
		end
	end

	assign grey = grey_s6;
endmodule

[rtl/core/gradient_noise_pixel_generator.sv]
// Top level of the gradient noise pixel generator: config, scaling, smoothstep and control.
// Pipeline: an accepted item reaches noise_value through 1 scale multiply, 36 divider
//   stages, 5 hash/table stages and 6 blend stages; one item per clock while out_stall is low.
// The divider depth follows from the lattice position width, one quotient bit per stage.
// A stalled result holds the whole pipe; bubbles travel as cleared valid bits.
// Reset clears valid bits and restores width 256, height 256, scale 2048, seed 0.
module gradient_noise_pixel_generator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [gnpg_pkg::PIX_W-1:0]    pix_x,
	input  logic [gnpg_pkg::PIX_W-1:0]    pix_y,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [gnpg_pkg::GREY_W-1:0]   noise_value,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [1:0]                    cfg_index,
	input  logic [gnpg_pkg::CFG_W-1:0]    cfg_data
);
	import gnpg_pkg::*;

	localparam int LAT = 1 + NUM_W + HASH_LAT + BLEND_LAT;
	localparam int SM_DLY = HASH_LAT - 2;

	// configuration registers
	logic [DIM_W-1:0]   image_width_q, image_height_q;
	logic [SCALE_W-1:0] noise_scale_q;
	logic [SEED_W-1:0]  noise_seed_q;

	// one valid bit per pipeline stage
	logic [LAT-1:0] vld_q;
	logic adv;

	logic [PROD_W-1:0] prod_x_s1, prod_y_s1;
	logic [DIM_W-1:0]  den_x, den_y;
	logic [NUM_W-1:0]  pos_x, pos_y;

	logic [FRAC_BITS-1:0] fx, fy;
	logic [FRAC_BITS-1:0] fx_dly_q [HASH_LAT];
	logic [FRAC_BITS-1:0] fy_dly_q [HASH_LAT];
	logic [FRAC_BITS-1:0] tx2_s1, ty2_s1;
	logic [FRAC_BITS+1:0] twx_s1, twy_s1;
	logic [2*FRAC_BITS+1:0] smx_full, smy_full;
	logic [SM_W-1:0] sx_s2, sy_s2;
	logic [SM_W-1:0] sx_dly_q [SM_DLY];
	logic [SM_W-1:0] sy_dly_q [SM_DLY];

	q14_t grad_cos [4];
	q14_t grad_sin [4];

	// whole pipe moves unless a finished result is held off
	assign adv       = !(vld_q[LAT-1] && out_stall);
	assign in_stall  = !adv;
	assign out_valid = vld_q[LAT-1];
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= DIM_W'(256);
			image_height_q <= DIM_W'(256);
			noise_scale_q  <= SCALE_W'(2048);
			noise_seed_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				REG_WIDTH:  image_width_q  <= cfg_data[DIM_W-1:0];
				REG_HEIGHT: image_height_q <= cfg_data[DIM_W-1:0];
				REG_SCALE:  noise_scale_q  <= cfg_data[SCALE_W-1:0];
				REG_SEED:   noise_seed_q   <= cfg_data[SEED_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	// stage 1: pixel times scale; the Q8.8 scale and the fraction shift meet in the divider
	always_ff @(posedge clk) begin
		if (adv) begin
			prod_x_s1 <= PROD_W'(pix_x) * PROD_W'(noise_scale_q);
			prod_y_s1 <= PROD_W'(pix_y) * PROD_W'(noise_scale_q);
		end
	end

	// zero dimension divides as one
	assign den_x = (image_width_q == '0) ? DIM_W'(1) : image_width_q;
	assign den_y = (image_height_q == '0) ? DIM_W'(1) : image_height_q;

	gnpg_div u_div_x (
		.clk (clk),
		.adv (adv),
		.num ({prod_x_s1, (FRAC_BITS - 8)'(0)}),
		.den (den_x),
		.quo (pos_x)
	);

	gnpg_div u_div_y (
		.clk (clk),
		.adv (adv),
		.num ({prod_y_s1, (FRAC_BITS - 8)'(0)}),
		.den (den_y),
		.quo (pos_y)
	);

	assign fx = pos_x[FRAC_BITS-1:0];
	assign fy = pos_y[FRAC_BITS-1:0];

	// corner gradients from the integer cell
	gnpg_hash u_hash (
		.clk      (clk),
		.adv      (adv),
		.cell_x   (pos_x[NUM_W-1:FRAC_BITS]),
		.cell_y   (pos_y[NUM_W-1:FRAC_BITS]),
		.seed     (noise_seed_q),
		.grad_cos (grad_cos),
		.grad_sin (grad_sin)
	);

	// smoothstep in two multiply stages, run beside the hash
	always_comb begin
		smx_full = (2*FRAC_BITS+2)'(tx2_s1) * (2*FRAC_BITS+2)'(twx_s1);
		smy_full = (2*FRAC_BITS+2)'(ty2_s1) * (2*FRAC_BITS+2)'(twy_s1);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tx2_s1 <= FRAC_BITS'(((2*FRAC_BITS)'(fx) * (2*FRAC_BITS)'(fx)) >> FRAC_BITS);
			ty2_s1 <= FRAC_BITS'(((2*FRAC_BITS)'(fy) * (2*FRAC_BITS)'(fy)) >> FRAC_BITS);
			twx_s1 <= (FRAC_BITS+2)'(3) * ((FRAC_BITS+2)'(1) << FRAC_BITS) - {1'b0, fx, 1'b0};
			twy_s1 <= (FRAC_BITS+2)'(3) * ((FRAC_BITS+2)'(1) << FRAC_BITS) - {1'b0, fy, 1'b0};
			sx_s2  <= SM_W'(smx_full >> FRAC_BITS);
			sy_s2  <= SM_W'(smy_full >> FRAC_BITS);
			fx_dly_q[0] <= fx;
			fy_dly_q[0] <= fy;
			sx_dly_q[0] <= sx_s2;
			sy_dly_q[0] <= sy_s2;
			for (int i = 1; i < HASH_LAT; i++) begin
				fx_dly_q[i] <= fx_dly_q[i-1];
				fy_dly_q[i] <= fy_dly_q[i-1];
			end
			for (int i = 1; i < SM_DLY; i++) begin
				sx_dly_q[i] <= sx_dly_q[i-1];
				sy_dly_q[i] <= sy_dly_q[i-1];
			end
		end
	end

	gnpg_blend u_blend (
		.clk      (clk),
		.adv      (adv),
		.frac_x   (fx_dly_q[HASH_LAT-1]),
		.frac_y   (fy_dly_q[HASH_LAT-1]),
		.smooth_x (sx_dly_q[SM_DLY-1]),
		.smooth_y (sy_dly_q[SM_DLY-1]),
		.grad_cos (grad_cos),
		.grad_sin (grad_sin),
		.grey     (noise_value)
	);

	// an accepted item enters the first stage
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> vld_q[0])
		else $error("accepted item missing from first stage");

	// after a result leaves, the next one comes from the stage behind it
	a_out_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall) |=> (out_valid == $past(vld_q[LAT-2])))
		else $error("output valid out of step with pipeline");

	// seed write lands
	a_seed_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready && (cfg_idx_t'(cfg_index) == REG_SEED))
		|=> (noise_seed_q == $past(cfg_data)))
		else $error("seed register not written");

endmodule
